// ===== design/ddar_pkg.sv =====
package ddar_pkg;

   // Field widths fixed by the item formats
   localparam int PLAYER_W = 16;
   localparam int TGT_W    = 9;
   localparam int RAY_W    = 12;
   localparam int PIX_W    = 14;
   localparam int SCALE_W  = 7;
   localparam int MAP_W    = 8;
   localparam int DEC_W    = 8;

   // Datapath widths
   localparam int DELTA_W = 16;             // signed whole-pixel delta
   localparam int STEPS_W = 15;             // magnitude of a delta
   localparam int REM_W   = STEPS_W + 1;    // divider remainder
   localparam int OPA_W   = 17;             // signed multiplier operand
   localparam int OPB_W   = SCALE_W + 1;    // signed view of the scale
   localparam int MUL_W   = OPA_W + OPB_W;  // product

   localparam logic [PIX_W-1:0] PIX_MAX = {PIX_W{1'b1}};

   // Configuration port
   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 8;
   localparam logic [CSR_ADDR_W-1:0] CSR_PIXEL_SCALE    = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_MAP_WIDTH      = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_MAP_HEIGHT     = 2'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_RAY_DECIMATION = 2'd3;

   localparam logic [SCALE_W-1:0] PIXEL_SCALE_RST    = 7'd16;
   localparam logic [MAP_W-1:0]   MAP_WIDTH_RST      = 8'd32;
   localparam logic [MAP_W-1:0]   MAP_HEIGHT_RST     = 8'd32;
   localparam logic [DEC_W-1:0]   RAY_DECIMATION_RST = 8'd8;

   // Parameter defaults
   localparam int MAX_PIXELS_DEF = 64;
   localparam int FRAC_BITS_DEF  = 16;

   typedef enum logic [3:0] {
      S_IDLE,
      S_MOD_START,
      S_MOD_WAIT,
      S_MUL_DX,
      S_MUL_DY,
      S_MUL_SX,
      S_MUL_SY,
      S_STEPS,
      S_DIVX_START,
      S_DIVX_WAIT,
      S_DIVY_START,
      S_DIVY_WAIT,
      S_EMIT
   } state_type;

   // Sequencer to divider
   typedef struct packed {
      logic start;
      logic mod_mode;   // 1: remainder of a RAY_W-bit value, 0: fraction quotient
   } div_cmd_type;

   // Divider to sequencer
   typedef struct packed {
      logic done;
      logic rem_zero;
   } div_sts_type;

endpackage

// ===== design/ddar_div_unit.sv =====
module ddar_div_unit #(
   parameter int FRAC_BITS = ddar_pkg::FRAC_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  ddar_pkg::div_cmd_type         cmd,
   input  logic [ddar_pkg::STEPS_W-1:0]  num,
   input  logic [ddar_pkg::STEPS_W-1:0]  den,
   output ddar_pkg::div_sts_type         sts,
   output logic [FRAC_BITS:0]            quo
);
   import ddar_pkg::*;

   localparam int QUO_W  = FRAC_BITS + 1;
   localparam int BITS_W = (QUO_W > RAY_W) ? QUO_W : RAY_W;
   localparam int CNT_W  = $clog2(BITS_W + 1);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [REM_W-1:0]  rem_ff, rem_in;
   logic [BITS_W-1:0] bits_ff, bits_in;
   logic [QUO_W-1:0]  quo_ff, quo_in;
   logic [STEPS_W-1:0] den_ff, den_in;

   logic [REM_W:0] cand;
   logic [REM_W:0] diff;
   logic           ge;

   // One restoring step: shift in the next dividend bit, subtract if it fits
   assign cand = {rem_ff, bits_ff[BITS_W-1]};
   assign ge   = cand >= (REM_W+1)'(den_ff);
   assign diff = cand - (REM_W+1)'(den_ff);

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      bits_in = bits_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      if (cmd.start) begin
         busy_in = 1'b1;
         den_in  = den;
         quo_in  = '0;
         if (cmd.mod_mode) begin
            cnt_in  = CNT_W'(RAY_W);
            rem_in  = '0;
            bits_in = BITS_W'(num[RAY_W-1:0]) << (BITS_W - RAY_W);
         end else begin
            // |delta| <= steps, so half of it is already a valid remainder
            cnt_in  = CNT_W'(QUO_W);
            rem_in  = REM_W'(num >> 1);
            bits_in = BITS_W'(num[0]) << (BITS_W - 1);
         end
      end else if (busy_ff) begin
         rem_in  = ge ? diff[REM_W-1:0] : cand[REM_W-1:0];
         bits_in = bits_ff << 1;
         quo_in  = {quo_ff[QUO_W-2:0], ge};
         cnt_in  = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff  <= rem_in;
      bits_ff <= bits_in;
      quo_ff  <= quo_in;
      den_ff  <= den_in;
   end

   assign sts.done     = done_ff;
   assign sts.rem_zero = (rem_ff == '0);
   assign quo          = quo_ff;

`ifndef ASSERT_OFF
   a_done_after_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(busy_ff))
      else $error("divider done without a running division");
   a_no_restart_busy: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> !cmd.start)
      else $error("divider started while busy");
   a_rem_below_den: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> rem_ff < REM_W'(den_ff))
      else $error("divider remainder not below divisor");
`endif

endmodule

// ===== design/dda_ray_line_rasterizer_unit.sv =====
// DDA ray line rasterizer for a minimap. Each req item carries a player
// position (unsigned Q8.8 cell units), a target cell and a ray index. Rays
// whose target lies outside the map, or whose index is not a multiple of
// ray_decimation (0 counts as 1), produce no rsp items. Otherwise both points
// are scaled by pixel_scale, the per-axis deltas are truncated toward zero to
// whole pixels, steps is the larger absolute delta, and the increments
// delta/steps are formed in signed fixed point with FRAC_BITS fractional bits.
// The block then emits min(steps+1, MAX_PIXELS) pixels, one per cycle while
// rsp_tready is high; the final one carries tlast, and tuser when the run was
// cut at MAX_PIXELS. Pixel coordinates clamp to 0..16383.
// Flow: one item at a time; req_tready is high only while idle. An item
// with an out-of-map target is dropped in S_IDLE as it is accepted. The
// setup is paced by the single shared compare-subtract divider, which
// retires one remainder or quotient bit per cycle: the RAY_W-bit remainder
// for the decimation check, then FRAC_BITS+1 quotient bits for each of the
// two increments; and by the one multiplier that forms the two deltas and
// two start positions in S_MUL_DX through S_MUL_SY. The last pixel sits in
// the rsp output register, so the next req item is accepted while it waits.
module dda_ray_line_rasterizer_unit #(
   parameter int MAX_PIXELS = ddar_pkg::MAX_PIXELS_DEF,
   parameter int FRAC_BITS  = ddar_pkg::FRAC_BITS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   // tdata: player_x[15:0], player_y[31:16], target_col[40:32],
   //        target_row[49:41], ray_index[61:50], zero fill [63:62]
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [63:0]                      req_tdata,
   // tdata: pixel_x[13:0], pixel_y[27:14], zero fill [31:28]
   // tlast: last, tuser: truncated
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [31:0]                      rsp_tdata,
   output logic                             rsp_tlast,
   output logic                             rsp_tuser,
   input  logic                             csr_we,
   input  logic [ddar_pkg::CSR_ADDR_W-1:0]  csr_addr,
   input  logic [ddar_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import ddar_pkg::*;

   localparam int QUO_W = FRAC_BITS + 1;
   localparam int INC_W = FRAC_BITS + 2;
   localparam int POS_W = FRAC_BITS + 17;
   localparam int HI_W  = POS_W - FRAC_BITS;
   localparam int CNT_W = $clog2(MAX_PIXELS);

   // Configuration registers
   logic [SCALE_W-1:0] pixel_scale_ff;
   logic [MAP_W-1:0]   map_width_ff;
   logic [MAP_W-1:0]   map_height_ff;
   logic [DEC_W-1:0]   ray_decimation_ff;

   state_type state_ff, state_in;

   // Captured item
   logic [PLAYER_W-1:0] px_ff, px_in;
   logic [PLAYER_W-1:0] py_ff, py_in;
   logic [MAP_W-1:0]    tc_ff, tc_in;
   logic [MAP_W-1:0]    tr_ff, tr_in;
   logic [RAY_W-1:0]    ri_ff, ri_in;

   // Setup datapath
   logic signed [MUL_W-1:0]   mul_ff, mul_in;
   logic signed [DELTA_W-1:0] dx_ff, dx_in;
   logic signed [DELTA_W-1:0] dy_ff, dy_in;
   logic [STEPS_W-1:0]        steps_ff, steps_in;
   logic signed [INC_W-1:0]   xinc_ff, xinc_in;
   logic signed [INC_W-1:0]   yinc_ff, yinc_in;
   logic signed [POS_W-1:0]   posx_ff, posx_in;
   logic signed [POS_W-1:0]   posy_ff, posy_in;
   logic [CNT_W-1:0]          k_ff, k_in;
   logic [CNT_W-1:0]          last_idx_ff, last_idx_in;
   logic                      cut_ff, cut_in;

   // Output register
   logic             rsp_valid_ff, rsp_valid_in;
   logic [PIX_W-1:0] rsp_x_ff, rsp_x_in;
   logic [PIX_W-1:0] rsp_y_ff, rsp_y_in;
   logic             rsp_last_ff, rsp_last_in;
   logic             rsp_trunc_ff, rsp_trunc_in;

   // Input fields
   logic [PLAYER_W-1:0] req_player_x;
   logic [PLAYER_W-1:0] req_player_y;
   logic [TGT_W-1:0]    req_target_col;
   logic [TGT_W-1:0]    req_target_row;
   logic [RAY_W-1:0]    req_ray_index;

   logic                      req_accept;
   logic                      map_ok;
   logic [DEC_W-1:0]          dec_eff;
   logic signed [OPA_W-1:0]   mul_a;
   logic signed [OPB_W-1:0]   mul_b;
   logic [STEPS_W-1:0]        adx;
   logic [STEPS_W-1:0]        ady;
   logic                      run_cut;
   logic                      slot_free;
   logic                      emit_load;
   logic                      emit_last;
   logic signed [DELTA_W-1:0] mul_delta;
   logic [POS_W-1:0]          mul_start;

   div_cmd_type              div_cmd;
   div_sts_type              div_sts;
   logic [STEPS_W-1:0]       div_num;
   logic [STEPS_W-1:0]       div_den;
   logic [QUO_W-1:0]         div_quo;
   logic signed [INC_W-1:0]  quo_signed;

   // Truncate a running position to a pixel, clamping at both ends
   function automatic logic [PIX_W-1:0] to_pixel(input logic signed [POS_W-1:0] pos);
      logic [HI_W-1:0] hi;
      hi = pos[POS_W-1:FRAC_BITS];
      if (pos[POS_W-1])
         return '0;
      else if (hi > HI_W'(PIX_MAX))
         return PIX_MAX;
      else
         return hi[PIX_W-1:0];
   endfunction

   assign req_player_x   = req_tdata[15:0];
   assign req_player_y   = req_tdata[31:16];
   assign req_target_col = req_tdata[40:32];
   assign req_target_row = req_tdata[49:41];
   assign req_ray_index  = req_tdata[61:50];

   assign req_accept = req_tvalid && req_tready;
   assign map_ok = !req_target_col[TGT_W-1] && (req_target_col[MAP_W-1:0] < map_width_ff)
                && !req_target_row[TGT_W-1] && (req_target_row[MAP_W-1:0] < map_height_ff);
   assign dec_eff = (ray_decimation_ff == '0) ? DEC_W'(1) : ray_decimation_ff;

   // ------------------------------------------------------------------
   // Configuration writes
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         pixel_scale_ff    <= PIXEL_SCALE_RST;
         map_width_ff      <= MAP_WIDTH_RST;
         map_height_ff     <= MAP_HEIGHT_RST;
         ray_decimation_ff <= RAY_DECIMATION_RST;
      end else if (csr_we) begin
         case (csr_addr)
            CSR_PIXEL_SCALE:    pixel_scale_ff    <= csr_wdata[SCALE_W-1:0];
            CSR_MAP_WIDTH:      map_width_ff      <= csr_wdata[MAP_W-1:0];
            CSR_MAP_HEIGHT:     map_height_ff     <= csr_wdata[MAP_W-1:0];
            CSR_RAY_DECIMATION: ray_decimation_ff <= csr_wdata[DEC_W-1:0];
            default: ;
         endcase
      end
   end

   // ------------------------------------------------------------------
   // Shared divider: ray_index mod decimation, then |dx|/steps, |dy|/steps
   // ------------------------------------------------------------------
   ddar_div_unit #(
      .FRAC_BITS (FRAC_BITS)
   ) u_div (
      .clock (clock),
      .reset (reset),
      .cmd   (div_cmd),
      .num   (div_num),
      .den   (div_den),
      .sts   (div_sts),
      .quo   (div_quo)
   );

   assign quo_signed = INC_W'(div_quo);

   // ------------------------------------------------------------------
   // Sequencer: next state
   // ------------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE:       if (req_accept && map_ok) state_in = S_MOD_START;
         S_MOD_START:  state_in = S_MOD_WAIT;
         S_MOD_WAIT: begin
            if (div_sts.done) state_in = div_sts.rem_zero ? S_MUL_DX : S_IDLE;
         end
         S_MUL_DX:     state_in = S_MUL_DY;
         S_MUL_DY:     state_in = S_MUL_SX;
         S_MUL_SX:     state_in = S_MUL_SY;
         S_MUL_SY:     state_in = S_STEPS;
         S_STEPS:      state_in = S_DIVX_START;
         S_DIVX_START: state_in = (steps_ff == '0) ? S_EMIT : S_DIVX_WAIT;
         S_DIVX_WAIT:  if (div_sts.done) state_in = S_DIVY_START;
         S_DIVY_START: state_in = S_DIVY_WAIT;
         S_DIVY_WAIT:  if (div_sts.done) state_in = S_EMIT;
         S_EMIT:       if (emit_load && emit_last) state_in = S_IDLE;
         default:      state_in = S_IDLE;
      endcase
   end

   // ------------------------------------------------------------------
   // Sequencer: outputs
   // ------------------------------------------------------------------
   always_comb begin
      req_tready       = 1'b0;
      div_cmd.start    = 1'b0;
      div_cmd.mod_mode = 1'b0;
      div_num          = adx;
      div_den          = steps_ff;
      mul_a            = '0;
      case (state_ff)
         S_IDLE:      req_tready = 1'b1;
         S_MOD_START: begin
            div_cmd.start    = 1'b1;
            div_cmd.mod_mode = 1'b1;
            div_num          = STEPS_W'(ri_ff);
            div_den          = STEPS_W'(dec_eff);
         end
         // target*256 - player, as a signed Q8.8 difference in cell units before scaling
         S_MUL_DX:     mul_a = signed'({1'b0, tc_ff, 8'h00}) - signed'({1'b0, px_ff});
         S_MUL_DY:     mul_a = signed'({1'b0, tr_ff, 8'h00}) - signed'({1'b0, py_ff});
         S_MUL_SX:     mul_a = signed'({1'b0, px_ff});
         S_MUL_SY:     mul_a = signed'({1'b0, py_ff});
         S_DIVX_START: div_cmd.start = (steps_ff != '0);
         S_DIVY_START: begin
            div_cmd.start = 1'b1;
            div_num       = ady;
         end
         default: ;
      endcase
   end

   assign mul_b = signed'({1'b0, pixel_scale_ff});

   // Scaled delta divided by 256, truncated toward zero
   assign mul_delta = DELTA_W'((mul_ff + (mul_ff[MUL_W-1] ? MUL_W'(255) : MUL_W'(0))) >>> 8);
   // Scaled start position widened from Q.8 to Q.FRAC_BITS
   assign mul_start = POS_W'(mul_ff) << (FRAC_BITS - 8);

   assign adx = dx_ff[DELTA_W-1] ? STEPS_W'(-dx_ff) : STEPS_W'(dx_ff);
   assign ady = dy_ff[DELTA_W-1] ? STEPS_W'(-dy_ff) : STEPS_W'(dy_ff);

   assign run_cut   = {1'b0, steps_ff} >= (STEPS_W+1)'(MAX_PIXELS);
   assign slot_free = !rsp_valid_ff || rsp_tready;
   assign emit_load = (state_ff == S_EMIT) && slot_free;
   assign emit_last = (k_ff == last_idx_ff);

   // ------------------------------------------------------------------
   // Datapath next values
   // ------------------------------------------------------------------
   always_comb begin
      px_in       = px_ff;
      py_in       = py_ff;
      tc_in       = tc_ff;
      tr_in       = tr_ff;
      ri_in       = ri_ff;
      mul_in      = mul_a * mul_b;
      dx_in       = dx_ff;
      dy_in       = dy_ff;
      steps_in    = steps_ff;
      xinc_in     = xinc_ff;
      yinc_in     = yinc_ff;
      posx_in     = posx_ff;
      posy_in     = posy_ff;
      k_in        = k_ff;
      last_idx_in = last_idx_ff;
      cut_in      = cut_ff;

      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_x_in     = rsp_x_ff;
      rsp_y_in     = rsp_y_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_trunc_in = rsp_trunc_ff;

      case (state_ff)
         S_IDLE: begin
            // capture the item; an out-of-map target is dropped here
            px_in = req_player_x;
            py_in = req_player_y;
            tc_in = req_target_col[MAP_W-1:0];
            tr_in = req_target_row[MAP_W-1:0];
            ri_in = req_ray_index;
         end
         S_MUL_DY: dx_in   = mul_delta;
         S_MUL_SX: dy_in   = mul_delta;
         S_MUL_SY: posx_in = signed'(mul_start);
         S_STEPS: begin
            posy_in  = signed'(mul_start);
            steps_in = (adx > ady) ? adx : ady;
         end
         S_DIVX_START: begin
            // zero steps: a single start pixel, no increments
            xinc_in     = '0;
            yinc_in     = '0;
            k_in        = '0;
            cut_in      = run_cut;
            last_idx_in = run_cut ? CNT_W'(MAX_PIXELS - 1) : steps_ff[CNT_W-1:0];
         end
         S_DIVX_WAIT: begin
            if (div_sts.done) xinc_in = dx_ff[DELTA_W-1] ? -quo_signed : quo_signed;
         end
         S_DIVY_WAIT: begin
            if (div_sts.done) yinc_in = dy_ff[DELTA_W-1] ? -quo_signed : quo_signed;
         end
         S_EMIT: begin
            if (emit_load) begin
               rsp_valid_in = 1'b1;
               rsp_x_in     = to_pixel(posx_ff);
               rsp_y_in     = to_pixel(posy_ff);
               rsp_last_in  = emit_last;
               rsp_trunc_in = emit_last && cut_ff;
               // advance the running position after every pixel
               posx_in      = posx_ff + POS_W'(xinc_ff);
               posy_in      = posy_ff + POS_W'(yinc_ff);
               k_in         = k_ff + CNT_W'(1);
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      px_ff        <= px_in;
      py_ff        <= py_in;
      tc_ff        <= tc_in;
      tr_ff        <= tr_in;
      ri_ff        <= ri_in;
      mul_ff       <= mul_in;
      dx_ff        <= dx_in;
      dy_ff        <= dy_in;
      steps_ff     <= steps_in;
      xinc_ff      <= xinc_in;
      yinc_ff      <= yinc_in;
      posx_ff      <= posx_in;
      posy_ff      <= posy_in;
      k_ff         <= k_in;
      last_idx_ff  <= last_idx_in;
      cut_ff       <= cut_in;
      rsp_x_ff     <= rsp_x_in;
      rsp_y_ff     <= rsp_y_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_trunc_ff <= rsp_trunc_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'b0000, rsp_y_ff, rsp_x_ff};
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = rsp_trunc_ff;

`ifndef ASSERT_OFF
   a_emit_count_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_EMIT |-> k_ff <= last_idx_ff)
      else $error("pixel counter ran past the end of the run");
   a_trunc_on_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (!rsp_tuser || rsp_tlast))
      else $error("truncated flag on a pixel that is not the last");
   a_done_while_waiting: assert property (@(posedge clock) disable iff (reset)
      div_sts.done |-> (state_ff == S_MOD_WAIT || state_ff == S_DIVX_WAIT
                        || state_ff == S_DIVY_WAIT))
      else $error("divider finished outside a wait state");
   a_no_emit_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> state_ff != S_EMIT)
      else $error("emission started right after an accepted item");
`endif

endmodule
